[src/alist_pkg.sv]
// Package for the array list engine: field widths, operation and status codes, FSM states.
`timescale 1ns / 1ps
package alist_pkg;

  // Fixed field widths of the channels and the register.
  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int POS_W   = 4;
  localparam int STAT_W  = 2;
  localparam int MEAN_W  = 40;
  localparam int CNT_W   = 5;
  localparam int CAP_W   = 5;
  localparam int FRAC_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Reset value of the capacity limit register.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes; the two codes above read reverse are unused.
  typedef enum logic [OP_W-1:0] {
    OP_APPEND      = 3'd0,
    OP_REMOVE_LAST = 3'd1,
    OP_REMOVE_AT   = 3'd2,
    OP_MEAN        = 3'd3,
    OP_READ_FWD    = 3'd4,
    OP_READ_REV    = 3'd5
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Control states of the engine.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_DIV  = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

endpackage

[src/alist_in_if.sv]
// Input channel interface of the array list engine.
`timescale 1ns / 1ps
interface alist_in_if;
  logic                        valid;
  logic                        ready;
  logic [alist_pkg::OP_W-1:0]  operation;
  logic signed [alist_pkg::KEY_W-1:0] key_in;
  logic [alist_pkg::POS_W-1:0] position;

  modport source (output valid, operation, key_in, position, input ready);
  modport sink   (input valid, operation, key_in, position, output ready);
endinterface

[src/alist_out_if.sv]
// Result channel interface of the array list engine.
`timescale 1ns / 1ps
interface alist_out_if;
  logic                                valid;
  logic                                ready;
  logic [alist_pkg::STAT_W-1:0]        status;
  logic signed [alist_pkg::KEY_W-1:0]  key_out;
  logic signed [alist_pkg::MEAN_W-1:0] mean_value;
  logic [alist_pkg::CNT_W-1:0]         entry_count;
  logic                                last_result;

  modport source (output valid, status, key_out, mean_value, entry_count, last_result,
                  input ready);
  modport sink   (input valid, status, key_out, mean_value, entry_count, last_result,
                  output ready);
endinterface

[src/alist_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module alist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[src/array_list_engine.sv]
// Top level of the array list engine: list control, key store, mean divider, result register.
//
// The block holds an ordered list of signed 32-bit keys. Each word on the input
// channel (in_ch) carries one operation: append, remove last, remove at position,
// mean, read forward or read reverse. Results leave on out_ch, one word per key for
// a read of a non-empty list, else one word; last_result marks the final word.
// The APB port sets capacity_limit at byte address 0; the user makes writes while
// idle, which the block does not enforce. With n the number of keys held:
//   append, remove last, errors, unused codes: one result word from the response state.
//   remove at position: later keys move down one place (one key moved per
//   cycle), then the count drops; none moves when the last key is removed.
//   reads: keys leave one per cycle while the result register can take them.
//   mean: the n keys are summed, then a 1-bit-per-cycle divider of
//   DW = 45 steps at DEPTH 16 gives the result.
// One word is processed at a time; in_ch.ready is high only when the engine is idle.
// Cycle counts are set by the single read port of the key store and the divider.
// Reset (rst_n low, synchronous) empties the list, sets capacity_limit to 16 and
// drops any pending result. When out_ch.ready is low, the result register holds
// its word and the engine waits once it has another word to load; no word is lost.
`timescale 1ns / 1ps
module array_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  alist_in_if.sink                      in_ch,
  alist_out_if.source                   out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [alist_pkg::PADDR_W-1:0] paddr,
  input  logic [alist_pkg::PDATA_W-1:0] pwdata,
  output logic [alist_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import alist_pkg::*;

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
  localparam int PCW  = (CW > POS_W) ? CW : POS_W;
  localparam int SW   = KEY_W + $clog2(DEPTH + 1);
  localparam int DW   = SW + FRAC_W;
  localparam int DCW  = $clog2(DW + 1);

  // Control state.
  state_t          state_r, state_nxt;
  op_t             op_r, op_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [AW-1:0]   rd_addr_r, rd_addr_nxt;
  logic [AW-1:0]   lst_addr_r, lst_addr_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic            pend_r, pend_nxt;
  logic [DCW-1:0]  div_cnt_r, div_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic [DW-1:0]        div_q_r, div_q_nxt;
  logic [CW-1:0]        div_rem_r, div_rem_nxt;
  logic                 neg_r, neg_nxt;
  status_t              status_r, status_nxt;
  logic [MEAN_W-1:0]    mean_r, mean_nxt;
  logic [STAT_W-1:0]    out_status_r;
  logic [KEY_W-1:0]     out_key_r;
  logic [MEAN_W-1:0]    out_mean_r;
  logic [CW-1:0]        out_count_r;
  logic                 out_last_r;

  // Key store port signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [KEY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // Result register load.
  logic             load_out;
  status_t          ld_status;
  logic [KEY_W-1:0] ld_key;
  logic [MEAN_W-1:0] ld_mean;
  logic             ld_last;

  // Helper terms.
  logic            can_load;
  logic            is_full;
  logic            pos_bad;
  logic            consume;
  logic            is_read;
  logic [CW:0]     div_shift;
  logic            div_ge;
  logic [CW:0]     div_diff;
  logic [SW-1:0]   sum_mag;
  logic [DW-1:0]   quo_signed;
  logic            cfg_we;

  alist_ram #(
    .WIDTH(KEY_W),
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_key_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Configuration port: capacity_limit is the only register.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr[PADDR_W-1];
  assign prdata = !paddr[PADDR_W-1] ? PDATA_W'(cap_r) : '0;

  // Handshake and result outputs.
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.key_out     = out_key_r;
  assign out_ch.mean_value  = out_mean_r;
  assign out_ch.entry_count = CNT_W'(out_count_r);
  assign out_ch.last_result = out_last_r;

  assign can_load = !out_valid_r || out_ch.ready;
  assign is_full  = (CMPW'(count_r) >= CMPW'(cap_r)) || (count_r == CW'(DEPTH));
  assign pos_bad  = PCW'(in_ch.position) >= PCW'(count_r);
  assign is_read  = (op_r == OP_READ_FWD) || (op_r == OP_READ_REV);
  assign consume  = pend_r && (!is_read || can_load);

  // Divider step: one quotient bit per cycle, divisor is the entry count.
  assign div_shift  = {div_rem_r, div_q_r[DW-1]};
  assign div_ge     = div_shift >= {1'b0, count_r};
  assign div_diff   = div_shift - {1'b0, count_r};
  assign sum_mag    = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
  assign quo_signed = neg_r ? (~div_q_r + DW'(1)) : div_q_r;

  // Next-state and datapath logic.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    count_nxt    = count_r;
    rd_addr_nxt  = rd_addr_r;
    lst_addr_nxt = lst_addr_r;
    rem_nxt      = rem_r;
    pend_nxt     = pend_r;
    div_cnt_nxt  = div_cnt_r;
    sum_nxt      = sum_r;
    div_q_nxt    = div_q_r;
    div_rem_nxt  = div_rem_r;
    neg_nxt      = neg_r;
    status_nxt   = status_r;
    mean_nxt     = mean_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    load_out     = 1'b0;
    ld_status    = ST_OK;
    ld_key       = '0;
    ld_mean      = '0;
    ld_last      = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt     = op_t'(in_ch.operation);
          status_nxt = ST_OK;
          mean_nxt   = '0;
          state_nxt  = S_RESP;
          pend_nxt   = 1'b0;
          if ((count_r == '0) && (in_ch.operation != OP_APPEND) &&
              (in_ch.operation <= OP_READ_REV)) begin
            status_nxt = ST_EMPTY;
          end else begin
            case (op_t'(in_ch.operation))
              OP_APPEND: begin
                if (is_full) begin
                  status_nxt = ST_FULL;
                end else begin
                  ram_we    = 1'b1;
                  ram_waddr = AW'(count_r);
                  ram_wdata = in_ch.key_in;
                  count_nxt = count_r + CW'(1);
                end
              end
              OP_REMOVE_LAST: begin
                count_nxt = count_r - CW'(1);
              end
              OP_REMOVE_AT: begin
                if (pos_bad) begin
                  status_nxt = ST_BADPOS;
                end else begin
                  rd_addr_nxt = AW'(PCW'(in_ch.position) + PCW'(1));
                  rem_nxt     = CW'(PCW'(count_r) - PCW'(in_ch.position) - PCW'(1));
                  state_nxt   = S_WALK;
                end
              end
              OP_MEAN: begin
                rd_addr_nxt = '0;
                rem_nxt     = count_r;
                sum_nxt     = '0;
                state_nxt   = S_WALK;
              end
              OP_READ_FWD: begin
                rd_addr_nxt = '0;
                rem_nxt     = count_r;
                state_nxt   = S_WALK;
              end
              OP_READ_REV: begin
                rd_addr_nxt = AW'(count_r - CW'(1));
                rem_nxt     = count_r;
                state_nxt   = S_WALK;
              end
              default: begin
              end
            endcase
          end
        end
      end

      // Walk the store: one read issued, one earlier used per cycle; reads wait on out_ch.
      S_WALK: begin
        if (!pend_r && (rem_r == '0)) begin
          case (op_r)
            OP_MEAN: begin
              div_q_nxt   = {sum_mag, {FRAC_W{1'b0}}};
              div_rem_nxt = '0;
              neg_nxt     = sum_r[SW-1];
              div_cnt_nxt = DCW'(DW);
              state_nxt   = S_DIV;
            end
            OP_REMOVE_AT: begin
              count_nxt = count_r - CW'(1);
              state_nxt = S_RESP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end else begin
          if (consume) begin
            case (op_r)
              OP_MEAN: begin
                sum_nxt = sum_r + {{(SW-KEY_W){ram_rdata[KEY_W-1]}}, ram_rdata};
              end
              OP_REMOVE_AT: begin
                ram_we    = 1'b1;
                ram_waddr = lst_addr_r - AW'(1);
                ram_wdata = ram_rdata;
              end
              default: begin
                load_out = 1'b1;
                ld_key   = ram_rdata;
                ld_last  = (rem_r == '0);
              end
            endcase
          end
          if (!pend_r || consume) begin
            if (rem_r != '0) begin
              ram_re       = 1'b1;
              ram_raddr    = rd_addr_r;
              lst_addr_nxt = rd_addr_r;
              rd_addr_nxt  = (op_r == OP_READ_REV) ? rd_addr_r - AW'(1)
                                                   : rd_addr_r + AW'(1);
              rem_nxt      = rem_r - CW'(1);
              pend_nxt     = 1'b1;
            end else begin
              pend_nxt = 1'b0;
            end
          end
        end
      end

      // Restoring division of |sum| * 256 by the entry count.
      S_DIV: begin
        if (div_cnt_r == '0) begin
          mean_nxt  = quo_signed[MEAN_W-1:0];
          state_nxt = S_RESP;
        end else begin
          div_rem_nxt = div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
          div_q_nxt   = {div_q_r[DW-2:0], div_ge};
          div_cnt_nxt = div_cnt_r - DCW'(1);
        end
      end

      // Single-word result waits for a free result register.
      S_RESP: begin
        if (can_load) begin
          load_out  = 1'b1;
          ld_status = status_r;
          ld_mean   = mean_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      op_r        <= OP_APPEND;
      rem_r       <= '0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      rem_r       <= rem_nxt;
      div_cnt_r   <= div_cnt_nxt;
      if (cfg_we) begin
        cap_r <= pwdata[CAP_W-1:0];
      end
    end
  end

  // Payload registers; the count travels with its word so that a waiting
  // word keeps the count of its own operation.
  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    lst_addr_r <= lst_addr_nxt;
    sum_r      <= sum_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    neg_r      <= neg_nxt;
    status_r   <= status_nxt;
    mean_r     <= mean_nxt;
    if (load_out) begin
      out_status_r <= ld_status;
      out_key_r    <= ld_key;
      out_mean_r   <= ld_mean;
      out_count_r  <= count_r;
      out_last_r   <= ld_last;
    end
  end

endmodule

[bench/tb_array_list_engine.sv]
// Self-checking testbench for the array list engine: directed rows, then random phases.
`timescale 1ns / 1ps
module tb_array_list_engine;
  import alist_pkg::*;

  localparam int DEPTH = 16;
  localparam int NUM_ROWS = 24;
  localparam int NUM_PHASES = 6;
  localparam int HOLD_AT_WORD = 60;
  localparam int HOLD_CYCLES = 120;
  localparam int SETTLE_CYCLES = 80;

  // Register address of the capacity limit.
  localparam logic [PADDR_W-1:0] REG_CAPACITY = '0;

  // Operation codes that the block must answer with a plain ok word.
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  // One result word as the block should deliver it.
  typedef struct packed {
    status_t                   status;
    logic signed [KEY_W-1:0]   key_out;
    logic signed [MEAN_W-1:0]  mean_value;
    logic [CNT_W-1:0]          entry_count;
    logic                      last_result;
  } result_word_t;

  // One directed row; the typed status and count apply where pinned is set.
  typedef struct packed {
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        pos;
    logic                    pinned;
    status_t                 status;
    logic [CNT_W-1:0]        count;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  alist_in_if  in_ch ();
  alist_out_if out_ch ();

  array_list_engine #(.DEPTH(DEPTH)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the list as the block should hold it.
  logic signed [KEY_W-1:0] shadow_keys [DEPTH];
  int                      shadow_count;
  int                      shadow_capacity;

  // Words the block still owes, oldest first.
  result_word_t owed_words [$];

  int errors;
  int words_seen;
  bit calm;

  // Opening rows: empty-list errors, spare codes, key extremes, bad positions.
  stim_row_t opening_rows [NUM_ROWS] = '{
    '{OP_REMOVE_LAST, 32'sd0,           4'd0,  1'b1, ST_EMPTY,  5'd0},
    '{OP_REMOVE_AT,   32'sd0,           4'd0,  1'b1, ST_EMPTY,  5'd0},
    '{OP_MEAN,        32'sd0,           4'd0,  1'b1, ST_EMPTY,  5'd0},
    '{OP_READ_FWD,    32'sd0,           4'd0,  1'b1, ST_EMPTY,  5'd0},
    '{OP_READ_REV,    32'sd0,           4'd0,  1'b1, ST_EMPTY,  5'd0},
    '{OP_SPARE_6,     32'sd0,           4'd15, 1'b1, ST_OK,     5'd0},
    '{OP_SPARE_7,     -32'sd1,          4'd15, 1'b1, ST_OK,     5'd0},
    '{OP_APPEND,      32'sh7FFF_FFFF,   4'd15, 1'b1, ST_OK,     5'd1},
    '{OP_APPEND,      32'sh8000_0000,   4'd0,  1'b1, ST_OK,     5'd2},
    '{OP_APPEND,      -32'sd1,          4'd0,  1'b1, ST_OK,     5'd3},
    '{OP_APPEND,      32'sd0,           4'd0,  1'b1, ST_OK,     5'd4},
    '{OP_APPEND,      32'sd12345,       4'd0,  1'b1, ST_OK,     5'd5},
    '{OP_MEAN,        32'sd0,           4'd0,  1'b0, ST_OK,     5'd0},
    '{OP_READ_FWD,    32'sd0,           4'd0,  1'b0, ST_OK,     5'd0},
    '{OP_READ_REV,    32'sd0,           4'd0,  1'b0, ST_OK,     5'd0},
    '{OP_REMOVE_AT,   32'sd0,           4'd15, 1'b1, ST_BADPOS, 5'd5},
    '{OP_REMOVE_AT,   32'sd0,           4'd5,  1'b1, ST_BADPOS, 5'd5},
    '{OP_REMOVE_AT,   32'sd0,           4'd1,  1'b1, ST_OK,     5'd4},
    '{OP_REMOVE_AT,   32'sd0,           4'd3,  1'b1, ST_OK,     5'd3},
    '{OP_REMOVE_LAST, 32'sd0,           4'd0,  1'b1, ST_OK,     5'd2},
    '{OP_READ_REV,    32'sd0,           4'd0,  1'b0, ST_OK,     5'd0},
    '{OP_MEAN,        32'sd0,           4'd0,  1'b0, ST_OK,     5'd0},
    '{OP_APPEND,      -32'sd3,          4'd0,  1'b1, ST_OK,     5'd3},
    '{OP_MEAN,        32'sd0,           4'd0,  1'b0, ST_OK,     5'd0}
  };

  // Capacity, length and append share of each random phase.
  int phase_capacity [NUM_PHASES] = '{0, 31, 3, 16, 1, 16};
  int phase_items    [NUM_PHASES] = '{12, 50, 30, 26, 20, 48};
  int phase_fill     [NUM_PHASES] = '{60, 70, 50, 45, 50, 55};

  // Clock.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Queue one expected word; the count is the one after the operation.
  function automatic void owe_word(status_t st, logic signed [KEY_W-1:0] key,
                                   logic signed [MEAN_W-1:0] mean, logic last);
    result_word_t w;
    w.status      = st;
    w.key_out     = key;
    w.mean_value  = mean;
    w.entry_count = CNT_W'(shadow_count);
    w.last_result = last;
    owed_words.push_back(w);
  endfunction

  // Apply one accepted operation to the shadow list and queue its words.
  function automatic void apply_list_op(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                                        logic [POS_W-1:0] pos);
    int     n;
    int     limit;
    longint total;
    n     = shadow_count;
    limit = (shadow_capacity > DEPTH) ? DEPTH : shadow_capacity;
    if (op != OP_APPEND && op <= OP_READ_REV && n == 0) begin
      owe_word(ST_EMPTY, '0, '0, 1'b1);
      return;
    end
    case (op)
      OP_APPEND: begin
        if (n >= limit) begin
          owe_word(ST_FULL, '0, '0, 1'b1);
        end else begin
          shadow_keys[n] = key;
          shadow_count = n + 1;
          owe_word(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_REMOVE_LAST: begin
        shadow_count = n - 1;
        owe_word(ST_OK, '0, '0, 1'b1);
      end
      OP_REMOVE_AT: begin
        if (int'(pos) >= n) begin
          owe_word(ST_BADPOS, '0, '0, 1'b1);
        end else begin
          for (int i = int'(pos); i + 1 < n; i++) shadow_keys[i] = shadow_keys[i + 1];
          shadow_count = n - 1;
          owe_word(ST_OK, '0, '0, 1'b1);
        end
      end
      OP_MEAN: begin
        total = 0;
        for (int i = 0; i < n; i++) total += longint'(shadow_keys[i]);
        // Signed division truncates toward zero.
        owe_word(ST_OK, '0, MEAN_W'((total * 256) / longint'(n)), 1'b1);
      end
      OP_READ_FWD: begin
        for (int i = 0; i < n; i++) owe_word(ST_OK, shadow_keys[i], '0, i == n - 1);
      end
      OP_READ_REV: begin
        for (int i = 0; i < n; i++) owe_word(ST_OK, shadow_keys[n - 1 - i], '0, i == n - 1);
      end
      default: begin
        owe_word(ST_OK, '0, '0, 1'b1);
      end
    endcase
  endfunction

  // Offer one word on the input channel, with an occasional idle burst first.
  task automatic offer_word(logic [OP_W-1:0] op, logic signed [KEY_W-1:0] key,
                            logic [POS_W-1:0] pos, logic pinned, status_t st,
                            logic [CNT_W-1:0] count);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_in    <= key;
    in_ch.position  <= pos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    apply_list_op(op, key, pos);
    // A typed expectation replaces the status and count of the single word.
    if (pinned) begin
      owed_words[owed_words.size() - 1].status      = st;
      owed_words[owed_words.size() - 1].entry_count = count;
    end
    @(negedge clk);
  endtask

  // Write the capacity limit, then read it back over the same port.
  task automatic program_capacity(int value);
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= REG_CAPACITY;
    pwdata  <= PDATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_capacity = value & 5'h1F;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    if (readback !== PDATA_W'(shadow_capacity)) begin
      $display("%0t ns: capacity readback mismatch, expected %0d, got %0d",
               $time, shadow_capacity, readback);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result sink: random stall bursts, one long hold-off, no stalls at the end.
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (!held && words_seen >= HOLD_AT_WORD) begin
        // Long hold-off so that the block fills up and stalls its input.
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    result_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (owed_words.size() == 0) begin
        $display({"%0t ns: unexpected result word, ",
                  "got status %0d key %0d mean %0d count %0d last %0d"},
                 $time, out_ch.status, out_ch.key_out, out_ch.mean_value,
                 out_ch.entry_count, out_ch.last_result);
        errors++;
      end else begin
        want = owed_words.pop_front();
        if (out_ch.status !== want.status || out_ch.key_out !== want.key_out ||
            out_ch.mean_value !== want.mean_value ||
            out_ch.entry_count !== want.entry_count ||
            out_ch.last_result !== want.last_result) begin
          $display({"%0t ns: result mismatch, expected ",
                    "status %0d key %0d mean %0d count %0d last %0d"},
                   $time, want.status, want.key_out, want.mean_value,
                   want.entry_count, want.last_result);
          $display({"%0t ns: result mismatch, got      ",
                    "status %0d key %0d mean %0d count %0d last %0d"},
                   $time, out_ch.status, out_ch.key_out, out_ch.mean_value,
                   out_ch.entry_count, out_ch.last_result);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases at several capacities.
  initial begin : stimulus
    logic [OP_W-1:0]         op;
    logic signed [KEY_W-1:0] key;
    logic [POS_W-1:0]        pos;
    int                      pick;
    errors          = 0;
    words_seen      = 0;
    calm            = 1'b0;
    shadow_count    = 0;
    shadow_capacity = int'(CAP_RESET);
    foreach (shadow_keys[i]) shadow_keys[i] = '0;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.operation = '0;
    in_ch.key_in    = '0;
    in_ch.position  = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset capacity; the write restores the same value.
    program_capacity(int'(CAP_RESET));
    foreach (opening_rows[r]) begin
      offer_word(opening_rows[r].op, opening_rows[r].key, opening_rows[r].pos,
                 opening_rows[r].pinned, opening_rows[r].status, opening_rows[r].count);
    end
    in_ch.valid <= 1'b0;

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The capacity only changes once the block has delivered everything.
      while (owed_words.size() != 0) @(negedge clk);
      program_capacity(phase_capacity[ph]);
      for (int k = 0; k < phase_items[ph]; k++) begin
        if (ph == NUM_PHASES - 1 && k >= phase_items[ph] - 30) calm = 1'b1;
        if ($urandom_range(0, 99) < phase_fill[ph]) begin
          op = OP_APPEND;
        end else begin
          pick = $urandom_range(0, 19);
          if (pick < 4) op = OP_REMOVE_LAST;
          else if (pick < 9) op = OP_REMOVE_AT;
          else if (pick < 12) op = OP_MEAN;
          else if (pick < 15) op = OP_READ_FWD;
          else if (pick < 18) op = OP_READ_REV;
          else if (pick == 18) op = OP_SPARE_6;
          else op = OP_SPARE_7;
        end
        // Keys lean toward the extremes now and then.
        pick = $urandom_range(0, 7);
        if (pick == 0) key = 32'sh7FFF_FFFF;
        else if (pick == 1) key = 32'sh8000_0000;
        else if (pick == 2) key = KEY_W'($signed($urandom_range(0, 200)) - 100);
        else key = $urandom;
        // Positions are mostly valid for the current list.
        if (shadow_count > 0 && $urandom_range(0, 3) != 0)
          pos = POS_W'($urandom_range(0, shadow_count - 1));
        else
          pos = POS_W'($urandom_range(0, 15));
        offer_word(op, key, pos, 1'b0, ST_OK, '0);
      end
      in_ch.valid <= 1'b0;
    end

    while (owed_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin : watchdog
    #10ms;
    $display("Verification failed");
    $finish;
  end

endmodule
